>>> hw/rtl/rhp_pkg.sv
// Package for the RGB to HSV pixel converter: widths, scale constants,
// lane codes and the reciprocal table used by the divide lanes.
// No dependencies.
package rhp_pkg;

  // Component and result widths
  localparam int unsigned COMP_W   = 8;
  localparam int unsigned HUE_W    = 13;
  localparam int unsigned SAT_W    = 15;
  localparam int unsigned VAL_W    = 15;
  localparam int unsigned SECNUM_W = 11;  // hue sector numerator, at most 6 * 255

  // Divide lane widths: numerator, reciprocal, quotient
  localparam int unsigned NUM_W       = 23;
  localparam int unsigned RECIP_SHIFT = 23;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
  localparam int unsigned PROD_W      = NUM_W + RECIP_W;
  localparam int unsigned Q_W         = 15;

  // Scale factors
  localparam int unsigned PCT_SCALE  = 25600;  // percent in 1/256 units
  localparam int unsigned HUE_SCALE  = 960;    // 60 degrees in 1/16 units
  localparam int unsigned COMP_MAX   = 255;
  localparam int unsigned HUE_LIMIT  = 5760;

  // Divide lanes
  localparam int unsigned N_LANES  = 3;
  localparam int unsigned LANE_SAT = 0;
  localparam int unsigned LANE_HUE = 1;
  localparam int unsigned LANE_VAL = 2;

  typedef logic [RECIP_W-1:0] recip_t;
  typedef recip_t recip_tab_t [2**COMP_W];

  // Build floor(2^RECIP_SHIFT / x) by shift-subtract long division; entry 0 is zero
  function automatic recip_tab_t build_recip();
    recip_tab_t          tab;
    logic [COMP_W:0]     rem;
    recip_t              q;
    tab[0] = '0;
    for (int x = 1; x < 2**COMP_W; x++) begin
      rem = '0;
      q   = '0;
      for (int b = RECIP_SHIFT; b >= 0; b--) begin
        rem = {rem[COMP_W-1:0], (b == RECIP_SHIFT)};
        if (rem >= (COMP_W+1)'(x)) begin
          rem  = rem - (COMP_W+1)'(x);
          q[b] = 1'b1;
        end
      end
      tab[x] = q;
    end
    return tab;
  endfunction

  localparam recip_tab_t RECIP = build_recip();

endpackage

>>> hw/rtl/rgb_to_hsv_pixel_top.sv
// done_o is registered and marks the cycle in which hue_o, saturation_o and brightness_o hold the result.
// Throughput: one pixel per clock; busy stays low, so start is taken every cycle.
// The five-stage pipeline (sort, scale, reciprocal multiply, back-multiply, correct) sets it.
// Reset: rst_ni asynchronous active low clears all stage valid bits; data is not reset.
// The receiver cannot hold results off.
// Depends on rhp_pkg.
module rgb_to_hsv_pixel_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [rhp_pkg::COMP_W-1:0] red_i,
  input  logic [rhp_pkg::COMP_W-1:0] green_i,
  input  logic [rhp_pkg::COMP_W-1:0] blue_i,
  output logic                      done_o,
  output logic [rhp_pkg::HUE_W-1:0]  hue_o,
  output logic [rhp_pkg::SAT_W-1:0]  saturation_o,
  output logic [rhp_pkg::VAL_W-1:0]  brightness_o
);
  import rhp_pkg::*;

  // Stage valid bits
  logic v1_q, v2_q, v3_q, v4_q, v5_q, done_q;

  // Stage 1: captured pixel
  logic [COMP_W-1:0] r1_q, g1_q, b1_q;

  // Stage 1 logic: max, min, spread, sector numerator
  logic [COMP_W-1:0]   mx1, mn1, d1;
  logic [SECNUM_W-1:0] sec1;

  // Stage 2: sorted values
  logic [COMP_W-1:0]   mx2_q, d2_q;
  logic [SECNUM_W-1:0] sec2_q;

  // Special-case flags travel with the data
  logic blk2_q, blk3_q, blk4_q, blk5_q;
  logic gry2_q, gry3_q, gry4_q, gry5_q;

  // Divide lanes
  logic [NUM_W-1:0]  n2    [N_LANES];
  logic [COMP_W-1:0] x2    [N_LANES];
  logic [NUM_W-1:0]  n3_q  [N_LANES];
  logic [COMP_W-1:0] x3_q  [N_LANES];
  recip_t            r3_q  [N_LANES];
  logic [PROD_W-1:0] p3    [N_LANES];
  logic [NUM_W-1:0]  n4_q  [N_LANES];
  logic [COMP_W-1:0] x4_q  [N_LANES];
  logic [Q_W-1:0]    q4_q  [N_LANES];
  logic [NUM_W-1:0]  m4    [N_LANES];
  logic [NUM_W-1:0]  n5_q  [N_LANES];
  logic [COMP_W-1:0] x5_q  [N_LANES];
  logic [Q_W-1:0]    q5_q  [N_LANES];
  logic [NUM_W-1:0]  m5_q  [N_LANES];
  logic [NUM_W-1:0]  rem5  [N_LANES];
  logic [Q_W-1:0]    q5    [N_LANES];

  // Output registers
  logic [HUE_W-1:0] hue_q;
  logic [SAT_W-1:0] sat_q;
  logic [VAL_W-1:0] val_q;

  // Never hold off a request
  assign busy = 1'b0;

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start && !busy;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      v5_q   <= v4_q;
      done_q <= v5_q;
    end
  end

  // Capture the pixel
  always_ff @(posedge clk_i) begin
    r1_q <= red_i;
    g1_q <= green_i;
    b1_q <= blue_i;
  end

  // Sort components and pick the hue sector, red first on ties
  always_comb begin
    mx1 = (r1_q > g1_q) ? r1_q : g1_q;
    if (b1_q > mx1) mx1 = b1_q;
    mn1 = (r1_q < g1_q) ? r1_q : g1_q;
    if (b1_q < mn1) mn1 = b1_q;
    d1 = mx1 - mn1;
    if (r1_q == mx1) begin
      if (g1_q >= b1_q) begin
        sec1 = SECNUM_W'(g1_q - b1_q);
      end else begin
        sec1 = SECNUM_W'(6) * SECNUM_W'(d1) - SECNUM_W'(b1_q - g1_q);
      end
    end else if (g1_q == mx1) begin
      sec1 = (SECNUM_W'(d1) << 1) + SECNUM_W'(b1_q) - SECNUM_W'(r1_q);
    end else begin
      sec1 = (SECNUM_W'(d1) << 2) + SECNUM_W'(r1_q) - SECNUM_W'(g1_q);
    end
  end

  always_ff @(posedge clk_i) begin
    mx2_q  <= mx1;
    d2_q   <= d1;
    sec2_q <= sec1;
    blk2_q <= (mx1 == '0);
    gry2_q <= (d1 == '0);
  end

  // Form numerators and divisors, look up reciprocals
  always_comb begin
    n2[LANE_SAT] = NUM_W'(d2_q) * NUM_W'(PCT_SCALE);
    n2[LANE_HUE] = NUM_W'(sec2_q) * NUM_W'(HUE_SCALE);
    n2[LANE_VAL] = NUM_W'(mx2_q) * NUM_W'(PCT_SCALE);
    x2[LANE_SAT] = mx2_q;
    x2[LANE_HUE] = d2_q;
    x2[LANE_VAL] = COMP_W'(COMP_MAX);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < N_LANES; i++) begin
      n3_q[i] <= n2[i];
      x3_q[i] <= x2[i];
      r3_q[i] <= RECIP[x2[i]];
    end
    blk3_q <= blk2_q;
    gry3_q <= gry2_q;
  end

  // Estimate quotients; each is exact or one low
  always_comb begin
    for (int i = 0; i < N_LANES; i++) begin
      p3[i] = PROD_W'(n3_q[i]) * PROD_W'(r3_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < N_LANES; i++) begin
      n4_q[i] <= n3_q[i];
      x4_q[i] <= x3_q[i];
      q4_q[i] <= p3[i][RECIP_SHIFT +: Q_W];
    end
    blk4_q <= blk3_q;
    gry4_q <= gry3_q;
  end

  // Multiply the estimate back by the divisor
  always_comb begin
    for (int i = 0; i < N_LANES; i++) begin
      m4[i] = NUM_W'(q4_q[i]) * NUM_W'(x4_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < N_LANES; i++) begin
      n5_q[i] <= n4_q[i];
      x5_q[i] <= x4_q[i];
      q5_q[i] <= q4_q[i];
      m5_q[i] <= m4[i];
    end
    blk5_q <= blk4_q;
    gry5_q <= gry4_q;
  end

  // Correct the estimate when the remainder reaches the divisor
  always_comb begin
    for (int i = 0; i < N_LANES; i++) begin
      rem5[i] = n5_q[i] - m5_q[i];
      q5[i]   = q5_q[i] + Q_W'(rem5[i] >= NUM_W'(x5_q[i]));
    end
  end

  // Apply black and gray cases and register results
  always_ff @(posedge clk_i) begin
    hue_q <= gry5_q ? '0 : q5[LANE_HUE][HUE_W-1:0];
    sat_q <= blk5_q ? '0 : SAT_W'(q5[LANE_SAT]);
    val_q <= VAL_W'(q5[LANE_VAL]);
  end

  assign done_o       = done_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = val_q;

  // Every result traces back to an earlier accepted request
  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 6))
    else $error("result without matching request");

  // Results stay in range
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (hue_o < HUE_W'(HUE_LIMIT)) && (saturation_o <= SAT_W'(PCT_SCALE))
               && (brightness_o <= VAL_W'(PCT_SCALE)))
    else $error("result out of range");

  // Black gives zero saturation and hue
  a_black_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (brightness_o == '0)) |-> (saturation_o == '0) && (hue_o == '0))
    else $error("black pixel with nonzero hue or saturation");

  // Zero saturation means gray, so hue is zero
  a_gray_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (saturation_o == '0)) |-> (hue_o == '0))
    else $error("gray pixel with nonzero hue");

endmodule
